// File: rtl/csrspmv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csrspmv_pkg
// item kinds, field widths and stream packing for the csr spmv block
// ----------------------------------------------------------------------------
package csrspmv_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_LOAD    = 2'd0;
  localparam mode_t MODE_NONZERO = 2'd1;
  localparam mode_t MODE_EMPTY   = 2'd2;

  localparam int MODE_W      = 2;
  localparam int INDEX_W     = 10;
  localparam int VALUE_W     = 32;
  localparam int ROW_INDEX_W = 16;
  localparam int ROW_SUM_W   = 64;

  // in tdata: index, value; out tdata: row_index, row_sum
  localparam int IN_TDATA_W  = ((INDEX_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ROW_INDEX_W + ROW_SUM_W + 7) / 8) * 8;

  typedef logic signed [VALUE_W-1:0]   value_t;
  typedef logic signed [ROW_SUM_W-1:0] sum_t;

endpackage

`default_nettype wire

// File: rtl/csr_sparse_matrix_vector_multiply.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply
// sparse matrix by dense vector product, matrix streamed in csr row order
// ----------------------------------------------------------------------------
// input beats carry a kind in in_tuser: load writes value into the vector
// store at index, nonzero multiplies value by the stored entry at column
// index and adds it to the running row sum, empty row closes the row.
// in_tlast on a nonzero closes the row after its product is added.
// each closed row gives one output beat: row_index in out_tdata[15:0] and
// the saturated q32.32 sum in out_tdata[79:16]; the sum then clears.
// one input beat is taken every cycle while in_tready is high. a row result
// passes through vector store read, multiply and accumulate into the output
// register. the accumulator adds one product per cycle unless the pipeline
// holds, so rows of any length stream without gaps. while a result waits for
// out_tready, beats keep flowing; in_tready drops only when a second result
// reaches the accumulator before the first is taken, and the pipeline then
// holds.
// reset clears the row counter, the sum and all pipeline valids; the
// vector store is not cleared and must be loaded before it is read.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply #(
  parameter int VECTOR_LENGTH = 1024,
  parameter int ROW_COUNT_MAX = 65536
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_tvalid,
  output logic                                   in_tready,
  input  wire [csrspmv_pkg::IN_TDATA_W-1:0]      in_tdata,   // index, value
  input  wire [csrspmv_pkg::MODE_W-1:0]          in_tuser,   // mode
  input  wire                                    in_tlast,   // row_end
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  output logic [csrspmv_pkg::OUT_TDATA_W-1:0]    out_tdata   // row_index, row_sum
);

  import csrspmv_pkg::*;

  localparam int AW  = $clog2(VECTOR_LENGTH);
  localparam int RCW = $clog2(ROW_COUNT_MAX);

  logic [VALUE_W-1:0] mem [VECTOR_LENGTH];

  logic [INDEX_W-1:0] in_index;
  value_t             in_value;
  logic [AW-1:0]      addr;
  logic               in_range;
  logic               accept;
  logic               stall;

  // stage 1: vector read
  logic               s1_v_r, s1_v_nxt;
  logic               s1_nz_r, s1_nz_nxt;
  logic               s1_fin_r, s1_fin_nxt;
  logic               s1_ok_r;
  value_t             s1_val_r;
  value_t             s1_rd_r;

  // stage 2: product
  logic               s2_v_r;
  logic               s2_fin_r;
  sum_t               s2_prod_r;
  sum_t               mul;
  sum_t               prod;

  // stage 3: accumulate and output
  sum_t               sum_r, sum_nxt;
  logic [RCW-1:0]     row_cnt_r, row_cnt_nxt;
  logic               out_v_r, out_v_nxt;
  logic [ROW_INDEX_W-1:0] out_idx_r, out_idx_nxt;
  sum_t               out_sum_r, out_sum_nxt;
  logic [ROW_SUM_W:0] wide_sum;
  sum_t               sat_sum;

  assign in_index = in_tdata[INDEX_W-1:0];
  assign in_value = in_tdata[INDEX_W+VALUE_W-1:INDEX_W];
  assign addr     = AW'(in_index);
  assign in_range = 17'(in_index) < 17'(VECTOR_LENGTH);

  assign stall     = s2_v_r && s2_fin_r && out_v_r && !out_tready;
  assign in_tready = !stall;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    s1_v_nxt   = 1'b0;
    s1_nz_nxt  = 1'b0;
    s1_fin_nxt = 1'b0;
    if (accept) begin
      unique case (in_tuser)
        MODE_NONZERO: begin
          s1_v_nxt   = 1'b1;
          s1_nz_nxt  = 1'b1;
          s1_fin_nxt = in_tlast;
        end
        MODE_EMPTY: begin
          s1_v_nxt   = 1'b1;
          s1_fin_nxt = 1'b1;
        end
        default: begin
          s1_v_nxt = 1'b0;
        end
      endcase
    end
  end

  // vector store
  always_ff @(posedge clk) begin
    if (accept && in_tuser == MODE_LOAD && in_range) begin
      mem[addr] <= in_value;
    end
    if (!stall) begin
      s1_rd_r  <= mem[addr];
      s1_val_r <= in_value;
      s1_ok_r  <= in_range;
    end
  end

  // full 64 bit signed product
  assign mul  = s1_val_r * s1_rd_r;
  assign prod = (s1_nz_r && s1_ok_r) ? mul : '0;

  always_ff @(posedge clk) begin
    if (!stall) begin
      s2_prod_r <= prod;
    end
  end

  // saturating accumulate
  assign wide_sum = {sum_r[ROW_SUM_W-1], sum_r} + {s2_prod_r[ROW_SUM_W-1], s2_prod_r};
  always_comb begin
    if (wide_sum[ROW_SUM_W] != wide_sum[ROW_SUM_W-1]) begin
      sat_sum = wide_sum[ROW_SUM_W] ? {1'b1, {(ROW_SUM_W-1){1'b0}}}
                                    : {1'b0, {(ROW_SUM_W-1){1'b1}}};
    end else begin
      sat_sum = wide_sum[ROW_SUM_W-1:0];
    end
  end

  always_comb begin
    sum_nxt     = sum_r;
    row_cnt_nxt = row_cnt_r;
    out_v_nxt   = out_v_r && !out_tready;
    out_idx_nxt = out_idx_r;
    out_sum_nxt = out_sum_r;
    if (s2_v_r && !stall) begin
      if (s2_fin_r) begin
        out_v_nxt   = 1'b1;
        out_idx_nxt = ROW_INDEX_W'(row_cnt_r);
        out_sum_nxt = sat_sum;
        sum_nxt     = '0;
        if (row_cnt_r == RCW'(ROW_COUNT_MAX - 1)) begin
          row_cnt_nxt = '0;
        end else begin
          row_cnt_nxt = row_cnt_r + 1'b1;
        end
      end else begin
        sum_nxt = sat_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_nz_r   <= 1'b0;
      s1_fin_r  <= 1'b0;
      s2_v_r    <= 1'b0;
      s2_fin_r  <= 1'b0;
      sum_r     <= '0;
      row_cnt_r <= '0;
      out_v_r   <= 1'b0;
    end else begin
      if (!stall) begin
        s1_v_r   <= s1_v_nxt;
        s1_nz_r  <= s1_nz_nxt;
        s1_fin_r <= s1_fin_nxt;
        s2_v_r   <= s1_v_r;
        s2_fin_r <= s1_fin_r;
      end
      sum_r     <= sum_nxt;
      row_cnt_r <= row_cnt_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r <= out_idx_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'({out_sum_r, out_idx_r});

endmodule

`default_nettype wire

// File: rtl/csrspmv_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csrspmv_checker
// port level checks for the csr spmv block
// ----------------------------------------------------------------------------
module csrspmv_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_tready,
  input wire                                 out_tvalid,
  input wire                                 out_tready,
  input wire [csrspmv_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import csrspmv_pkg::*;

  logic                   seen_r;
  logic [ROW_INDEX_W-1:0] last_idx_r;
  logic                   out_beat;

  assign out_beat = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_beat) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      last_idx_r <= out_tdata[ROW_INDEX_W-1:0];
    end
  end

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // input only waits behind a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // rows come out in order
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && seen_r |->
      out_tdata[ROW_INDEX_W-1:0] == last_idx_r + 1'b1 ||
      out_tdata[ROW_INDEX_W-1:0] == '0)
    else $error("row index out of sequence");

  // first row after reset is row zero
  a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && !seen_r |-> out_tdata[ROW_INDEX_W-1:0] == '0)
    else $error("first row index not zero");

  // nothing comes out straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind csr_sparse_matrix_vector_multiply csrspmv_checker u_csrspmv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: tb/csr_sparse_matrix_vector_multiply_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_tb
// self-checking bench for the csr sparse matrix by vector block
// ----------------------------------------------------------------------------
// vector loads and csr rows go in on the input stream. A scoreboard keeps its
// own vector store, row sum and row counter, and works out each row result.
// Results are compared with the oldest pending row in order. The sender and
// receiver idle at random in several phases. The run begins with a directed
// set covering saturation, empty rows and the unused kind.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply_tb;
  import csrspmv_pkg::*;

  localparam mode_t MODE_UNUSED = 2'd3;
  localparam int VEC_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int BEATS_PER_PHASE = 270;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hffff_0000;

  class row_sum_scoreboard;
    logic [VALUE_W-1:0] vec [VEC_DEPTH];
    sum_t row_acc;
    logic [ROW_INDEX_W-1:0] row_no;
    logic [ROW_INDEX_W-1:0] pending_row [$];
    sum_t pending_sum [$];
    int mismatches;

    function new();
      foreach (vec[i]) vec[i] = '0;
      row_acc = '0;
      row_no = '0;
      mismatches = 0;
    endfunction

    function void close_row();
      pending_row.push_back(row_no);
      pending_sum.push_back(row_acc);
      row_acc = '0;
      row_no = row_no + 1'b1;
    endfunction

    function void note_beat(mode_t kind, logic [INDEX_W-1:0] col,
                            logic [VALUE_W-1:0] val, logic last);
      value_t a;
      value_t b;
      sum_t prod;
      logic signed [ROW_SUM_W:0] wide;
      case (kind)
        MODE_LOAD: begin
          vec[col] = val;
        end
        MODE_NONZERO: begin
          a = val;
          b = vec[col];
          prod = a * b;
          wide = row_acc + prod;
          if (wide[ROW_SUM_W] != wide[ROW_SUM_W-1])
            row_acc = wide[ROW_SUM_W] ? {1'b1, {(ROW_SUM_W-1){1'b0}}}
                                      : {1'b0, {(ROW_SUM_W-1){1'b1}}};
          else
            row_acc = wide[ROW_SUM_W-1:0];
          if (last) close_row();
        end
        MODE_EMPTY: begin
          close_row();
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] beat);
      logic [ROW_INDEX_W-1:0] got_row;
      sum_t got_sum;
      logic [ROW_INDEX_W-1:0] exp_row;
      sum_t exp_sum;
      got_row = beat[ROW_INDEX_W-1:0];
      got_sum = beat[ROW_INDEX_W +: ROW_SUM_W];
      if (pending_row.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected row result: row %0d sum %0d", got_row, got_sum);
        return;
      end
      exp_row = pending_row.pop_front();
      exp_sum = pending_sum.pop_front();
      if (got_row !== exp_row) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row_index mismatch: expected %0d actual %0d", exp_row, got_row);
      end
      if (got_sum !== exp_sum) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row_sum mismatch on row %0d: expected %0d actual %0d",
                   exp_row, exp_sum, got_sum);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [MODE_W-1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  row_sum_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;
  int beats_sent = 0;
  bit loaded [VEC_DEPTH];
  int loaded_list [$];

  always #2 clk = ~clk;

  csr_sparse_matrix_vector_multiply dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // beat monitor and result receiver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_beat(mode_t'(in_tuser), in_tdata[INDEX_W-1:0],
                     in_tdata[INDEX_W +: VALUE_W], in_tlast);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata);
    end
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("csr_sparse_matrix_vector_multiply test failed");
      $finish;
    end
  end

  task automatic send_beat(mode_t kind, logic [INDEX_W-1:0] col,
                           logic [VALUE_W-1:0] val, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {{(IN_TDATA_W-INDEX_W-VALUE_W){1'b0}}, val, col};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    if (kind == MODE_LOAD && !loaded[col]) begin
      loaded[col] = 1'b1;
      loaded_list.push_back(int'(col));
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(19))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return Q_NEG_ONE;
      4: return Q_ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_loaded();
    return INDEX_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
  endfunction

  task automatic send_row();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(19) == 0)
        send_beat(MODE_LOAD, INDEX_W'($urandom), pick_value(), 1'($urandom));
      send_beat(MODE_NONZERO, pick_loaded(), pick_value(), 1'b0);
    end
    if ($urandom_range(9) == 0)
      send_beat(MODE_EMPTY, INDEX_W'($urandom), $urandom, 1'($urandom));
    else
      send_beat(MODE_NONZERO, pick_loaded(), pick_value(), 1'b1);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct);
    int start;
    int r;
    send_idle = idle_pct;
    recv_stall = stall_pct;
    start = beats_sent;
    while (beats_sent - start < BEATS_PER_PHASE) begin
      r = $urandom_range(99);
      if (r < 15) begin
        send_beat(MODE_LOAD, INDEX_W'($urandom), pick_value(), 1'($urandom));
      end else if (r < 85) begin
        send_row();
      end else if (r < 94) begin
        send_beat(MODE_EMPTY, INDEX_W'($urandom), $urandom, 1'($urandom));
      end else begin
        send_beat(MODE_UNUSED, INDEX_W'($urandom), $urandom, 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes loaded, row_end ignored on a load
    send_beat(MODE_LOAD, 10'd0, Q_MAX, 1'b1);
    send_beat(MODE_LOAD, 10'd1023, Q_MIN, 1'b0);
    send_beat(MODE_LOAD, 10'd512, Q_ONE, 1'b0);
    send_beat(MODE_LOAD, 10'd341, 32'hffff_ffff, 1'b0);
    send_beat(MODE_LOAD, 10'd682, 32'h0, 1'b0);
    // positive saturation, then back down from the limit
    repeat (3) send_beat(MODE_NONZERO, 10'd1023, Q_MIN, 1'b0);
    send_beat(MODE_NONZERO, 10'd0, Q_MIN, 1'b1);
    // negative saturation, closed by an empty row with tlast set
    send_beat(MODE_NONZERO, 10'd0, Q_MAX, 1'b0);
    repeat (4) send_beat(MODE_NONZERO, 10'd1023, Q_MAX, 1'b0);
    send_beat(MODE_EMPTY, 10'd1023, Q_MAX, 1'b1);
    send_beat(MODE_EMPTY, 10'd0, 32'h0, 1'b0);
    send_beat(MODE_UNUSED, 10'd1023, 32'hffff_ffff, 1'b1);
    // load then read straight away
    send_beat(MODE_LOAD, 10'd5, 32'h0002_0000, 1'b0);
    send_beat(MODE_NONZERO, 10'd5, Q_NEG_ONE, 1'b1);
    send_beat(MODE_NONZERO, 10'd512, Q_ONE, 1'b1);
    send_beat(MODE_NONZERO, 10'd341, Q_MIN, 1'b0);
    send_beat(MODE_NONZERO, 10'd682, 32'h1234_5678, 1'b1);

    run_phase(0, 0);
    run_phase(51, 0);
    run_phase(0, 51);
    run_phase(24, 24);
    in_tvalid <= 1'b0;

    while (sb.pending_row.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_row.size() == 0)
      $display("csr_sparse_matrix_vector_multiply test passed");
    else
      $display("csr_sparse_matrix_vector_multiply test failed");
    $finish;
  end

endmodule
